// ===== src/mdw_pkg.sv =====
// Shared types and constants for the match degree weighting block.
// No dependencies; used by every module under src except mdw_ram.
package mdw_pkg;

	localparam int FEAT_W   = 12;
	localparam int BOUND_W  = 17;
	localparam int WEIGHT_W = 17;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

	// configuration register indexes
	localparam logic CFG_LEFT_BOUND  = 1'b0;
	localparam logic CFG_RIGHT_BOUND = 1'b1;

	typedef enum logic [1:0] {
		FN_CLEAR = 2'd0,
		FN_COUNT = 2'd1,
		FN_WEIGH = 2'd2,
		FN_NONE  = 2'd3
	} func_t;

	// one queued item
	typedef struct packed {
		func_t              func;
		logic [FEAT_W-1:0]  left_feature;
		logic [FEAT_W-1:0]  right_feature;
	} cmd_t;

	// queue head toward the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

	typedef enum logic [2:0] {
		B_CLR,
		B_IDLE,
		B_RD,
		B_CHK,
		B_DIVL,
		B_DIVR
	} back_state_t;

endpackage

// ===== src/mdw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mdw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/mdw_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on mdw_pkg.
module mdw_div #(
	parameter int COUNT_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mdw_pkg::BOUND_W-1:0] dividend,
	input  logic [COUNT_BITS-1:0]       divisor,
	output logic                        done,
	output logic [mdw_pkg::BOUND_W-1:0] quotient
);

	localparam int CNT_W = $clog2(mdw_pkg::BOUND_W + 1);

	logic [COUNT_BITS-1:0]       rem_q;
	logic [COUNT_BITS-1:0]       dvs_q;
	logic [mdw_pkg::BOUND_W-1:0] quo_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        run_q;
	logic                        done_q;
	logic [COUNT_BITS:0]         trial;
	logic                        fits;

	// shift in next dividend bit and try to subtract
	assign trial = {rem_q, quo_q[mdw_pkg::BOUND_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(mdw_pkg::BOUND_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= fits ? COUNT_BITS'(trial - {1'b0, dvs_q}) : trial[COUNT_BITS-1:0];
			quo_q <= {quo_q[mdw_pkg::BOUND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== src/mdw_front.sv =====
// Front end: takes items, drops unused codes, and queues the rest (2 entries).
// Depends on mdw_pkg.
module mdw_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [1:0]                 func,
	input  logic [mdw_pkg::FEAT_W-1:0] left_feature,
	input  logic [mdw_pkg::FEAT_W-1:0] right_feature,
	output logic                       busy,
	output mdw_pkg::head_t             head,
	input  logic                       pop
);

	mdw_pkg::cmd_t slot_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          push;
	logic          take;

	assign busy = cnt_q == 2'd2;
	// unused code is accepted and forgotten
	assign push = start && !busy && (mdw_pkg::func_t'(func) != mdw_pkg::FN_NONE);
	assign take = pop && (cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (take) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, take};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= '{func: mdw_pkg::func_t'(func), left_feature: left_feature,
				right_feature: right_feature};
		end
	end

	assign head.valid = cnt_q != 2'd0;
	assign head.cmd   = slot_q[rd_q];

endmodule

// ===== src/mdw_back.sv =====
// Back end: count store sweeps, read-modify-write of counts, weight sequencing.
// Depends on mdw_pkg, mdw_ram, mdw_div.
module mdw_back #(
	parameter int FEATURE_IDS = 4096,
	parameter int COUNT_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mdw_pkg::head_t               head,
	output logic                         pop,
	input  logic [mdw_pkg::BOUND_W-1:0]  left_bound,
	input  logic [mdw_pkg::BOUND_W-1:0]  right_bound,
	output logic                         done,
	output logic [mdw_pkg::WEIGHT_W-1:0] weight,
	output logic                         count_missing
);

	localparam int ID_BITS = $clog2(FEATURE_IDS);
	localparam int EXT_W   = ID_BITS + mdw_pkg::FEAT_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	mdw_pkg::back_state_t state_q, state_d;
	mdw_pkg::cmd_t        cmd_q;
	logic [ID_BITS-1:0]   clr_q;
	logic [COUNT_BITS-1:0] rc_q;
	logic [mdw_pkg::BOUND_W-1:0] ql_q;
	logic [EXT_W-1:0]     lext, rext;
	logic [ID_BITS-1:0]   lslot, rslot;
	logic [COUNT_BITS-1:0] lrd, rrd;
	logic                 we;
	logic [ID_BITS-1:0]   lwa, rwa;
	logic [COUNT_BITS-1:0] lwd, rwd;
	logic                 div_start, div_done;
	logic [mdw_pkg::BOUND_W-1:0] div_a, div_q;
	logic [COUNT_BITS-1:0] div_b;
	logic [mdw_pkg::BOUND_W:0] sum;
	logic [mdw_pkg::WEIGHT_W-1:0] half;
	logic                 done_q, miss_q;
	logic [mdw_pkg::WEIGHT_W-1:0] weight_q;

	// feature id modulo table size (power of two)
	assign lext  = EXT_W'(cmd_q.left_feature);
	assign rext  = EXT_W'(cmd_q.right_feature);
	assign lslot = lext[ID_BITS-1:0];
	assign rslot = rext[ID_BITS-1:0];

	mdw_ram #(.WIDTH(COUNT_BITS), .DEPTH(FEATURE_IDS)) u_left_counts (
		.clk(clk), .we(we), .waddr(lwa), .wdata(lwd), .raddr(lslot), .rdata(lrd)
	);

	mdw_ram #(.WIDTH(COUNT_BITS), .DEPTH(FEATURE_IDS)) u_right_counts (
		.clk(clk), .we(we), .waddr(rwa), .wdata(rwd), .raddr(rslot), .rdata(rrd)
	);

	mdw_div #(.COUNT_BITS(COUNT_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .done(div_done), .quotient(div_q)
	);

	// mean of the two quotients, clipped at 1.0
	assign sum  = {1'b0, ql_q} + {1'b0, div_q};
	assign half = sum[mdw_pkg::BOUND_W:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mdw_pkg::B_CLR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (state_q == mdw_pkg::B_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == mdw_pkg::B_CHK && cmd_q.func == mdw_pkg::FN_WEIGH &&
				(lrd == '0 || rrd == '0)) begin
				done_q <= 1'b1;
			end
			if (state_q == mdw_pkg::B_DIVR && div_done) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.valid) begin
			cmd_q <= head.cmd;
		end
		if (state_q == mdw_pkg::B_CHK) begin
			rc_q     <= rrd;
			weight_q <= '0;
			miss_q   <= 1'b1;
		end
		if (state_q == mdw_pkg::B_DIVL && div_done) begin
			ql_q <= div_q;
		end
		if (state_q == mdw_pkg::B_DIVR && div_done) begin
			weight_q <= (half > mdw_pkg::WEIGHT_ONE) ? mdw_pkg::WEIGHT_ONE : half;
			miss_q   <= 1'b0;
		end
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		we        = 1'b0;
		lwa       = lslot;
		rwa       = rslot;
		lwd       = (lrd == CNT_MAX) ? lrd : lrd + 1'b1;
		rwd       = (rrd == CNT_MAX) ? rrd : rrd + 1'b1;
		div_start = 1'b0;
		div_a     = left_bound;
		div_b     = lrd;
		unique case (state_q)
			mdw_pkg::B_CLR: begin
				we  = 1'b1;
				lwa = clr_q;
				rwa = clr_q;
				lwd = '0;
				rwd = '0;
				if (clr_q == ID_BITS'(FEATURE_IDS - 1)) begin
					state_d = mdw_pkg::B_IDLE;
				end
			end
			mdw_pkg::B_IDLE: begin
				pop = 1'b1;
				if (head.valid) begin
					state_d = (head.cmd.func == mdw_pkg::FN_CLEAR) ? mdw_pkg::B_CLR
						: mdw_pkg::B_RD;
				end
			end
			mdw_pkg::B_RD: begin
				state_d = mdw_pkg::B_CHK;
			end
			mdw_pkg::B_CHK: begin
				if (cmd_q.func == mdw_pkg::FN_COUNT) begin
					we      = 1'b1;
					state_d = mdw_pkg::B_IDLE;
				end else if (lrd == '0 || rrd == '0) begin
					state_d = mdw_pkg::B_IDLE;
				end else begin
					div_start = 1'b1;
					state_d   = mdw_pkg::B_DIVL;
				end
			end
			mdw_pkg::B_DIVL: begin
				if (div_done) begin
					div_start = 1'b1;
					div_a     = right_bound;
					div_b     = rc_q;
					state_d   = mdw_pkg::B_DIVR;
				end
			end
			mdw_pkg::B_DIVR: begin
				if (div_done) begin
					state_d = mdw_pkg::B_IDLE;
				end
			end
			default: state_d = mdw_pkg::B_IDLE;
		endcase
	end

	assign done          = done_q;
	assign weight        = weight_q;
	assign count_missing = miss_q;

endmodule

// ===== src/match_degree_weighting.sv =====
// Top level of the match degree weighting block: config registers, front, back.
// Depends on mdw_pkg, mdw_front, mdw_back (and through it mdw_ram, mdw_div).
//
//  channel   handshake              payload
//  input     start / busy           func, left_feature, right_feature
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//  result    done (one cycle)       weight, count_missing
//
// A count item holds the back end for its pop, read and write back; a clear
// item for its pop plus the sweep. A weigh item with a zero count has its
// result registered on the ports after the pop, read and check states;
// otherwise two divisions, one after the other on one shared divider, put
// it there. After reset and after every clear item, both count stores are
// swept, one entry a cycle; queued items wait meanwhile.
// busy rises only when the two-entry queue is full; results cannot be stalled.
// FEATURE_IDS must be a power of two.
module match_degree_weighting #(
	parameter int FEATURE_IDS = 4096,
	parameter int COUNT_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   func,
	input  logic [mdw_pkg::FEAT_W-1:0]   left_feature,
	input  logic [mdw_pkg::FEAT_W-1:0]   right_feature,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [mdw_pkg::BOUND_W-1:0]  cfg_data,
	output logic                         done,
	output logic [mdw_pkg::WEIGHT_W-1:0] weight,
	output logic                         count_missing
);

	logic [mdw_pkg::BOUND_W-1:0] left_bound_q, right_bound_q;
	mdw_pkg::head_t head;
	logic           pop;

	// config registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_bound_q  <= mdw_pkg::BOUND_W'(65536);
			right_bound_q <= mdw_pkg::BOUND_W'(65536);
		end else if (cfg_valid) begin
			if (cfg_index == mdw_pkg::CFG_LEFT_BOUND) begin
				left_bound_q <= cfg_data;
			end
			if (cfg_index == mdw_pkg::CFG_RIGHT_BOUND) begin
				right_bound_q <= cfg_data;
			end
		end
	end

	mdw_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .func(func),
		.left_feature(left_feature), .right_feature(right_feature),
		.busy(busy), .head(head), .pop(pop)
	);

	mdw_back #(.FEATURE_IDS(FEATURE_IDS), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .pop(pop),
		.left_bound(left_bound_q), .right_bound(right_bound_q),
		.done(done), .weight(weight), .count_missing(count_missing)
	);

	// a missing count always yields zero weight
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && count_missing |-> weight == '0)
		else $error("missing count with nonzero weight");

	// weight never exceeds 1.0
	a_weight_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> weight <= mdw_pkg::WEIGHT_ONE)
		else $error("weight above 1.0");

	// one item at a time in the back end: no results in adjacent cycles
	a_no_back2back: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results in adjacent cycles");

endmodule
